/* design/assert_macros.svh */
// Assertion macros used by the timer queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
        else $error("timer queue check failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("timer queue check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("timer queue check failed");

`endif

/* design/dltq_pkg.sv */
// Types and constants shared by the delta list timer queue.
package dltq_pkg;

    localparam int ID_BITS       = 4;
    localparam int EXT_TIME_BITS = 24;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_ADVANCE  = 2'd2,
        REQ_RESERVED = 2'd3
    } t_req_type;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [2:0] {
        CO_HOLD     = 3'd0,
        CO_REMOVE   = 3'd1,
        CO_POP      = 3'd2,
        CO_INSERT   = 3'd3,
        CO_HEAD_SUB = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [ID_BITS-1:0] id;
    } t_cell_ctl;

endpackage

/* design/dltq_req_if.sv */
// Request channel: valid/ready handshake with the request fields.
interface dltq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  timer_id;
    logic [23:0] period_ms;
    logic        periodic;
    logic [23:0] elapsed_ms;

    modport source (output valid, req_type, timer_id, period_ms, periodic, elapsed_ms,
                    input ready);
    modport sink   (input valid, req_type, timer_id, period_ms, periodic, elapsed_ms,
                    output ready);
endinterface

/* design/dltq_rsp_if.sv */
// Result channel: valid/ready handshake with the result fields.
interface dltq_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [3:0]  expired_id;
    logic [23:0] head_timeout;
    logic        list_empty;
    logic        last;

    modport source (output valid, result_kind, expired_id, head_timeout, list_empty, last,
                    input ready);
    modport sink   (input valid, result_kind, expired_id, head_timeout, list_empty, last,
                    output ready);
endinterface

/* design/dltq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/dltq_cell.sv */
// One list cell: holds a timer entry and shifts with its neighbors.
module dltq_cell import dltq_pkg::*; #(
    parameter int IDX        = 0,
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 24,
    localparam int IW = $clog2(NUM_TIMERS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [IW-1:0]        i_pos,
    input  logic [TIME_BITS-1:0] i_new_delta,
    input  logic [TIME_BITS-1:0] i_new_period,
    input  logic                 i_new_periodic,
    input  logic [TIME_BITS-1:0] i_sub,
    input  logic                 i_prefix,
    output logic                 o_prefix,
    input  logic                 i_l_valid,
    input  logic [ID_BITS-1:0]   i_l_timer,
    input  logic [TIME_BITS-1:0] i_l_delta,
    input  logic [TIME_BITS-1:0] i_l_period,
    input  logic                 i_l_periodic,
    input  logic                 i_r_valid,
    input  logic [ID_BITS-1:0]   i_r_timer,
    input  logic [TIME_BITS-1:0] i_r_delta,
    input  logic [TIME_BITS-1:0] i_r_period,
    input  logic                 i_r_periodic,
    output logic                 o_valid,
    output logic [ID_BITS-1:0]   o_timer,
    output logic [TIME_BITS-1:0] o_delta,
    output logic [TIME_BITS-1:0] o_period,
    output logic                 o_periodic
);
    logic                 r_valid, n_valid;
    logic [ID_BITS-1:0]   r_timer, n_timer;
    logic [TIME_BITS-1:0] r_delta, n_delta;
    logic [TIME_BITS-1:0] r_period, n_period;
    logic                 r_periodic, n_periodic;
    logic                 w_hit;
    logic                 w_at_pos;
    logic                 w_above_pos;
    logic                 w_after_pos;

    assign w_hit       = (i_ctl.op == CO_REMOVE) && r_valid && (r_timer == i_ctl.id);
    assign o_prefix    = i_prefix | w_hit;
    assign w_at_pos    = (IW'(IDX) == i_pos);
    assign w_above_pos = (IW'(IDX) > i_pos);
    assign w_after_pos = (IDX >= 1) && (IW'(IDX - 1) == i_pos);

    always_comb begin
        n_valid    = r_valid;
        n_timer    = r_timer;
        n_delta    = r_delta;
        n_period   = r_period;
        n_periodic = r_periodic;
        case (i_ctl.op)
            CO_REMOVE, CO_POP: begin
                // close the gap: take the right neighbor from the hit onward
                if (i_prefix || w_hit) begin
                    n_valid    = i_r_valid;
                    n_timer    = i_r_timer;
                    n_delta    = i_r_delta;
                    n_period   = i_r_period;
                    n_periodic = i_r_periodic;
                end
                if (w_hit) begin
                    n_delta = i_r_delta + r_delta;
                end
            end
            CO_INSERT: begin
                if (w_at_pos) begin
                    n_valid    = 1'b1;
                    n_timer    = i_ctl.id;
                    n_delta    = i_new_delta;
                    n_period   = i_new_period;
                    n_periodic = i_new_periodic;
                end else if (w_above_pos) begin
                    n_valid    = i_l_valid;
                    n_timer    = i_l_timer;
                    n_delta    = w_after_pos ? (i_l_delta - i_sub) : i_l_delta;
                    n_period   = i_l_period;
                    n_periodic = i_l_periodic;
                end
            end
            CO_HEAD_SUB: begin
                if (IDX == 0) begin
                    n_delta = r_delta - i_sub;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_timer    <= n_timer;
        r_delta    <= n_delta;
        r_period   <= n_period;
        r_periodic <= n_periodic;
    end

    assign o_valid    = r_valid;
    assign o_timer    = r_timer;
    assign o_delta    = r_delta;
    assign o_period   = r_period;
    assign o_periodic = r_periodic;
endmodule

/* design/delta_list_timer_queue.sv */
// Top level of the delta list timer queue: sequencer, cell chain, expiry buffer.
//
//  channel | dir | beat contents
//  i_req   | in  | req_type, timer_id, period_ms, periodic, elapsed_ms
//  o_rsp   | out | result_kind, expired_id, head_timeout, list_empty, last
//
// One request at a time. Remove: drop step, then the status beat. Add: drop
// step, then an insertion walk over the list entries, then the status beat.
// Advance: pop and send each expired timer, then read the expired timers back
// and walk each periodic one into the list again, then the status beat.
// Reset is synchronous and empties the list at once. A stalled o_rsp holds
// the sequencer in the step that wants to send a beat.
`include "assert_macros.svh"

module delta_list_timer_queue import dltq_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_req_if.sink   i_req,
    dltq_rsp_if.source o_rsp
);
    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int LW = (TIME_BITS > EXT_TIME_BITS) ? TIME_BITS : EXT_TIME_BITS;
    localparam int RW = ID_BITS + TIME_BITS + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_REMOVE = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_ADV    = 7'b0001000,
        S_RD     = 7'b0010000,
        S_LD     = 7'b0100000,
        S_STATUS = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    t_req_type            r_type, n_type;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [TIME_BITS-1:0] r_period, n_period;
    logic                 r_per, n_per;
    logic [LW-1:0]        r_left, n_left;
    logic                 r_ret_rd, n_ret_rd;
    logic [IW-1:0]        r_ptr, n_ptr;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    logic [CW-1:0]        r_wcnt, n_wcnt;
    logic [CW-1:0]        r_rcnt, n_rcnt;

    logic                 r_o_valid, n_o_valid;
    logic                 r_o_kind, n_o_kind;
    logic [ID_BITS-1:0]   r_o_id, n_o_id;
    logic [23:0]          r_o_head, n_o_head;
    logic                 r_o_empty, n_o_empty;
    logic                 r_o_last, n_o_last;

    t_cell_ctl            w_ctl;
    logic [IW-1:0]        w_pos;
    logic [TIME_BITS-1:0] w_new_delta;
    logic [TIME_BITS-1:0] w_sub;
    logic                 w_out_free;
    logic                 w_full;
    logic [TIME_BITS-1:0] w_cur_delta;

    logic                 w_ram_we;
    logic [RW-1:0]        w_ram_wdata;
    logic [RW-1:0]        w_ram_rdata;
    logic [IW-1:0]        w_ram_raddr;

    logic [NUM_TIMERS-1:0] w_valid;
    logic [ID_BITS-1:0]    w_timer    [NUM_TIMERS];
    logic [TIME_BITS-1:0]  w_delta    [NUM_TIMERS];
    logic [TIME_BITS-1:0]  w_cperiod  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] w_cper;
    logic [NUM_TIMERS-1:0] w_pin;
    logic [NUM_TIMERS-1:0] w_pout;

    // cell chain
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        logic                 w_lv, w_rv, w_lp, w_rp;
        logic [ID_BITS-1:0]   w_lt, w_rt;
        logic [TIME_BITS-1:0] w_ld, w_rd, w_lpe, w_rpe;

        if (g == 0) begin : g_first
            assign w_lv     = 1'b0;
            assign w_lt     = '0;
            assign w_ld     = '0;
            assign w_lpe    = '0;
            assign w_lp     = 1'b0;
            assign w_pin[g] = (w_ctl.op == CO_POP);
        end else begin : g_mid
            assign w_lv     = w_valid[g-1];
            assign w_lt     = w_timer[g-1];
            assign w_ld     = w_delta[g-1];
            assign w_lpe    = w_cperiod[g-1];
            assign w_lp     = w_cper[g-1];
            assign w_pin[g] = w_pout[g-1];
        end

        if (g == NUM_TIMERS - 1) begin : g_last
            assign w_rv  = 1'b0;
            assign w_rt  = '0;
            assign w_rd  = '0;
            assign w_rpe = '0;
            assign w_rp  = 1'b0;
        end else begin : g_inner
            assign w_rv  = w_valid[g+1];
            assign w_rt  = w_timer[g+1];
            assign w_rd  = w_delta[g+1];
            assign w_rpe = w_cperiod[g+1];
            assign w_rp  = w_cper[g+1];
        end

        dltq_cell #(
            .IDX        (g),
            .NUM_TIMERS (NUM_TIMERS),
            .TIME_BITS  (TIME_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_pos          (w_pos),
            .i_new_delta    (w_new_delta),
            .i_new_period   (r_period),
            .i_new_periodic (r_per),
            .i_sub          (w_sub),
            .i_prefix       (w_pin[g]),
            .o_prefix       (w_pout[g]),
            .i_l_valid      (w_lv),
            .i_l_timer      (w_lt),
            .i_l_delta      (w_ld),
            .i_l_period     (w_lpe),
            .i_l_periodic   (w_lp),
            .i_r_valid      (w_rv),
            .i_r_timer      (w_rt),
            .i_r_delta      (w_rd),
            .i_r_period     (w_rpe),
            .i_r_periodic   (w_rp),
            .o_valid        (w_valid[g]),
            .o_timer        (w_timer[g]),
            .o_delta        (w_delta[g]),
            .o_period       (w_cperiod[g]),
            .o_periodic     (w_cper[g])
        );
    end

    // expired timers wait here until every expired timer has been popped
    dltq_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_TIMERS)
    ) u_exp_buf (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wcnt[IW-1:0]),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free  = !r_o_valid || o_rsp.ready;
    assign w_full      = w_valid[NUM_TIMERS-1];
    assign w_cur_delta = w_delta[r_ptr];
    assign w_ram_wdata = {w_timer[0], w_cperiod[0], w_cper[0]};
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_id        = r_id;
        n_period    = r_period;
        n_per       = r_per;
        n_left      = r_left;
        n_ret_rd    = r_ret_rd;
        n_ptr       = r_ptr;
        n_rem       = r_rem;
        n_wcnt      = r_wcnt;
        n_rcnt      = r_rcnt;
        n_o_valid   = r_o_valid && !o_rsp.ready;
        n_o_kind    = r_o_kind;
        n_o_id      = r_o_id;
        n_o_head    = r_o_head;
        n_o_empty   = r_o_empty;
        n_o_last    = r_o_last;
        w_ctl.op    = CO_HOLD;
        w_ctl.id    = r_id;
        w_pos       = r_ptr;
        w_new_delta = r_rem;
        w_sub       = '0;
        w_ram_we    = 1'b0;
        w_ram_raddr = r_rcnt[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type   = t_req_type'(i_req.req_type);
                    n_id     = i_req.timer_id;
                    n_period = TIME_BITS'(i_req.period_ms);
                    n_per    = i_req.periodic;
                    n_left   = LW'(i_req.elapsed_ms);
                    n_wcnt   = '0;
                    case (i_req.req_type)
                        REQ_ADD, REQ_REMOVE: n_state = S_REMOVE;
                        REQ_ADVANCE:         n_state = S_ADV;
                        default:             n_state = S_STATUS;
                    endcase
                end
            end
            S_REMOVE: begin
                // drop any active entry of this id; an add then walks in
                w_ctl.op = CO_REMOVE;
                if (r_type == REQ_ADD) begin
                    n_rem    = r_period;
                    n_ptr    = '0;
                    n_ret_rd = 1'b0;
                    n_state  = S_WALK;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_WALK: begin
                if (w_full) begin
                    n_state = r_ret_rd ? S_RD : S_STATUS;
                end else if (!w_valid[r_ptr]) begin
                    w_ctl.op = CO_INSERT;
                    n_state  = r_ret_rd ? S_RD : S_STATUS;
                end else if (r_rem > w_cur_delta) begin
                    n_rem = r_rem - w_cur_delta;
                    n_ptr = r_ptr + 1'b1;
                end else if (r_rem == w_cur_delta) begin
                    // equal time: place right after the matching entry
                    w_ctl.op    = CO_INSERT;
                    w_pos       = r_ptr + 1'b1;
                    w_new_delta = '0;
                    n_state     = r_ret_rd ? S_RD : S_STATUS;
                end else begin
                    w_ctl.op = CO_INSERT;
                    w_sub    = r_rem;
                    n_state  = r_ret_rd ? S_RD : S_STATUS;
                end
            end
            S_ADV: begin
                if (w_valid[0] && (LW'(w_delta[0]) <= r_left)) begin
                    if (w_out_free) begin
                        w_ctl.op  = CO_POP;
                        w_ram_we  = 1'b1;
                        n_wcnt    = r_wcnt + 1'b1;
                        n_left    = r_left - LW'(w_delta[0]);
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_EXPIRY;
                        n_o_id    = w_timer[0];
                        n_o_head  = '0;
                        n_o_empty = 1'b0;
                        n_o_last  = 1'b0;
                    end
                end else begin
                    if (w_valid[0]) begin
                        w_ctl.op = CO_HEAD_SUB;
                        w_sub    = TIME_BITS'(r_left);
                    end
                    n_rcnt  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_rcnt == r_wcnt) begin
                    n_state = S_STATUS;
                end else begin
                    n_rcnt  = r_rcnt + 1'b1;
                    n_state = S_LD;
                end
            end
            S_LD: begin
                // reload periodic timers in expiry order
                if (w_ram_rdata[0]) begin
                    n_id     = w_ram_rdata[RW-1 -: ID_BITS];
                    n_period = w_ram_rdata[TIME_BITS:1];
                    n_per    = 1'b1;
                    n_rem    = w_ram_rdata[TIME_BITS:1];
                    n_ptr    = '0;
                    n_ret_rd = 1'b1;
                    n_state  = S_WALK;
                end else begin
                    n_state = S_RD;
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_STATUS;
                    n_o_id    = '0;
                    n_o_head  = w_valid[0] ? 24'(w_delta[0]) : 24'd0;
                    n_o_empty = !w_valid[0];
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type    <= n_type;
        r_id      <= n_id;
        r_period  <= n_period;
        r_per     <= n_per;
        r_left    <= n_left;
        r_ret_rd  <= n_ret_rd;
        r_ptr     <= n_ptr;
        r_rem     <= n_rem;
        r_wcnt    <= n_wcnt;
        r_rcnt    <= n_rcnt;
        r_o_kind  <= n_o_kind;
        r_o_id    <= n_o_id;
        r_o_head  <= n_o_head;
        r_o_empty <= n_o_empty;
        r_o_last  <= n_o_last;
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.result_kind  = r_o_kind;
    assign o_rsp.expired_id   = r_o_id;
    assign o_rsp.head_timeout = r_o_head;
    assign o_rsp.list_empty   = r_o_empty;
    assign o_rsp.last         = r_o_last;

    // valid cells always form a prefix of the chain
    `ASSERT_ALWAYS(a_valid_prefix, i_clk, i_rst_n,
        (w_valid[NUM_TIMERS-1:1] & ~w_valid[NUM_TIMERS-2:0]) == '0)
    // the insertion walk never passes the end of the list
    `ASSERT_IMPL(a_walk_in_list, i_clk, i_rst_n, (r_state == S_WALK) && !w_full,
        (r_ptr == '0) || w_valid[r_ptr - 1'b1])
    // a found id frees the last cell
    `ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n,
        (r_state == S_REMOVE) && w_pout[NUM_TIMERS-1], !w_valid[NUM_TIMERS-1])
endmodule
